### hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the priority task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int unsigned MaxTasksDefault = 16;
  localparam int unsigned NumLocksDefault = 8;

  localparam logic [2:0] FuncCreate  = 3'd0;
  localparam logic [2:0] FuncTick    = 3'd1;
  localparam logic [2:0] FuncDelay   = 3'd2;
  localparam logic [2:0] FuncExit    = 3'd3;
  localparam logic [2:0] FuncAcquire = 3'd4;
  localparam logic [2:0] FuncRelease = 3'd5;

  localparam logic [2:0] StatDone     = 3'd0;
  localparam logic [2:0] StatFull     = 3'd1;
  localparam logic [2:0] StatIgnored  = 3'd2;
  localparam logic [2:0] StatBlocked  = 3'd3;
  localparam logic [2:0] StatIdle     = 3'd4;
  localparam logic [2:0] StatFinished = 3'd5;

  localparam logic [1:0] TsReady   = 2'd0;
  localparam logic [1:0] TsRunning = 2'd1;
  localparam logic [1:0] TsBlocked = 2'd2;
  localparam logic [1:0] TsDone    = 2'd3;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] task_id;
    logic       owner_boosted;
  } pts_result_t;

endpackage

`default_nettype wire

### hw/rtl/pts_core.sv
// ----------------------------------------------------------------------------
// pts_core
// Task table and sequencer; one entry is visited per cycle by a shared
// update and compare unit during tick and release sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_core
  import pts_pkg::*;
#(
  parameter int unsigned MaxTasks = MaxTasksDefault,
  parameter int unsigned NumLocks = NumLocksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [2:0]  func_i,
  input  wire logic [7:0]  prio_i,
  input  wire logic [15:0] ticks_i,
  input  wire logic [2:0]  lock_i,
  output logic             busy_o,
  output logic             done_o,
  output pts_result_t      res_o
);

  localparam int unsigned TW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CW = $clog2(MaxTasks + 1);
  localparam int unsigned LW = (NumLocks > 1) ? $clog2(NumLocks) : 1;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SSleep = 3'd1;
  localparam logic [2:0] SPick  = 3'd2;
  localparam logic [2:0] SWake  = 3'd3;
  localparam logic [2:0] SFin   = 3'd4;

  logic [1:0]  st_q   [MaxTasks];
  logic [7:0]  pr_q   [MaxTasks];
  logic [7:0]  bp_q   [MaxTasks];
  logic [15:0] sl_q   [MaxTasks];
  logic        wl_q   [MaxTasks];
  logic [NumLocks-1:0] held_q;
  logic [TW-1:0] own_q [NumLocks];
  logic [CW-1:0] cnt_q;
  logic          cur_v_q;
  logic [TW-1:0] cur_q;

  logic [2:0]    state_q;
  logic [CW-1:0] idx_q;
  logic          best_v_q, blk_q;
  logic [7:0]    best_p_q;
  logic [TW-1:0] best_q;
  logic          done_q;
  pts_result_t   res_q;

  logic          cur_run;
  logic          lk_ok;
  logic [LW-1:0] lk;
  logic [TW-1:0] ix;
  logic [TW-1:0] own;

  assign ix  = idx_q[TW-1:0];
  assign cur_run = cur_v_q && (st_q[cur_q] == TsRunning);
  assign lk_ok = ({29'd0, lock_i} < 32'(NumLocks));
  assign lk  = LW'(lock_i);
  assign own = own_q[lk];

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      cnt_q    <= '0;
      cur_v_q  <= 1'b0;
      cur_q    <= '0;
      held_q   <= '0;
      for (int k = 0; k < NumLocks; k++) own_q[k] <= '0;
      done_q   <= 1'b0;
      idx_q    <= '0;
      best_v_q <= 1'b0;
      blk_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (start_i) begin
            res_q <= '{status: StatIgnored, task_id: 4'd0, owner_boosted: 1'b0};
            idx_q <= '0;
            best_v_q <= 1'b0;
            blk_q <= 1'b0;
            best_p_q <= '0;
            case (func_i)
              FuncCreate: begin
                done_q <= 1'b1;
                if (cnt_q >= CW'(MaxTasks)) begin
                  res_q.status <= StatFull;
                end else begin
                  pr_q[cnt_q[TW-1:0]] <= prio_i;
                  bp_q[cnt_q[TW-1:0]] <= prio_i;
                  st_q[cnt_q[TW-1:0]] <= TsReady;
                  sl_q[cnt_q[TW-1:0]] <= '0;
                  wl_q[cnt_q[TW-1:0]] <= 1'b0;
                  cnt_q <= cnt_q + 1'b1;
                  res_q.status <= StatDone;
                  res_q.task_id <= 4'(cnt_q);
                end
              end
              FuncTick: begin
                state_q <= (cnt_q == '0) ? SFin : SSleep;
              end
              FuncDelay: begin
                done_q <= 1'b1;
                if (cur_run && ticks_i != '0) begin
                  sl_q[cur_q] <= ticks_i;
                  wl_q[cur_q] <= 1'b0;
                  st_q[cur_q] <= TsBlocked;
                  res_q.status <= StatDone;
                end
              end
              FuncExit: begin
                done_q <= 1'b1;
                if (cur_run) begin
                  st_q[cur_q] <= TsDone;
                  res_q.status <= StatDone;
                end
              end
              FuncAcquire: begin
                done_q <= 1'b1;
                if (lk_ok && cur_run) begin
                  if (!held_q[lk]) begin
                    held_q[lk] <= 1'b1;
                    own_q[lk] <= cur_q;
                    res_q.status <= StatDone;
                  end else begin
                    if (pr_q[cur_q] > pr_q[own]) begin
                      pr_q[own] <= pr_q[cur_q];
                      res_q.owner_boosted <= 1'b1;
                    end
                    st_q[cur_q] <= TsBlocked;
                    wl_q[cur_q] <= 1'b1;
                    sl_q[cur_q] <= '0;
                    res_q.status <= StatBlocked;
                  end
                end
              end
              FuncRelease: begin
                if (lk_ok && cur_run && held_q[lk] && own == cur_q) begin
                  held_q[lk] <= 1'b0;
                  own_q[lk] <= '0;
                  pr_q[cur_q] <= bp_q[cur_q];
                  res_q.status <= StatDone;
                  state_q <= SWake;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        SSleep: begin
          if (st_q[ix] == TsBlocked && !wl_q[ix] && sl_q[ix] != '0) begin
            sl_q[ix] <= sl_q[ix] - 1'b1;
            if (sl_q[ix] == 16'd1) st_q[ix] <= TsReady;
          end
          if (idx_q == cnt_q - 1'b1) begin
            idx_q <= '0;
            state_q <= SPick;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        SPick: begin
          if (st_q[ix] == TsReady || st_q[ix] == TsRunning) begin
            if (!best_v_q || pr_q[ix] > best_p_q) begin
              best_v_q <= 1'b1;
              best_p_q <= pr_q[ix];
              best_q <= ix;
            end
          end
          if (st_q[ix] == TsBlocked) blk_q <= 1'b1;
          if (idx_q == cnt_q - 1'b1) state_q <= SFin;
          else idx_q <= idx_q + 1'b1;
        end
        SWake: begin
          if (st_q[ix] == TsBlocked && wl_q[ix]) begin
            st_q[ix] <= TsReady;
            wl_q[ix] <= 1'b0;
          end
          if (idx_q == cnt_q - 1'b1) begin
            state_q <= SIdle;
            done_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        SFin: begin
          state_q <= SIdle;
          done_q <= 1'b1;
          if (best_v_q) begin
            if (cur_run && cur_q != best_q) st_q[cur_q] <= TsReady;
            st_q[best_q] <= TsRunning;
            cur_q <= best_q;
            cur_v_q <= 1'b1;
            res_q.status <= StatDone;
            res_q.task_id <= 4'(best_q);
          end else begin
            res_q.status <= blk_q ? StatIdle : StatFinished;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// Strict priority task scheduler with priority inheritance on locks.
// ----------------------------------------------------------------------------
// Usage: one event enters on the s_axis channel, one result leaves on the
// m_axis channel. Create, delay, exit and acquire are handled in the idle
// state. A tick with created tasks walks the task table twice, one entry
// a cycle through a shared update/compare unit. A successful release
// walks the table once.
// s_axis_tready is low while an event is in work or its result is
// unaccepted; a stall on m_axis holds the result and blocks the next event.
// Reset empties the task table, frees all locks and clears the current task.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_top
  import pts_pkg::*;
#(
  parameter int unsigned MaxTasks = MaxTasksDefault,
  parameter int unsigned NumLocks = NumLocksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[2:0], new_priority[10:3], delay_ticks[26:11], lock_index[29:27], zero
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], task_id[6:3], owner_boosted[7]
  output logic [7:0]       m_axis_tdata
);

  logic        busy, done, out_v_q;
  pts_result_t res;
  logic        start;

  assign s_axis_tready = !busy && !out_v_q && !done;
  assign start = s_axis_tvalid && s_axis_tready;

  pts_core #(.MaxTasks(MaxTasks), .NumLocks(NumLocks)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (s_axis_tdata[2:0]),
    .prio_i  (s_axis_tdata[10:3]),
    .ticks_i (s_axis_tdata[26:11]),
    .lock_i  (s_axis_tdata[29:27]),
    .busy_o  (busy),
    .done_o  (done),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (done) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {res.owner_boosted, res.task_id, res.status};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("event accepted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !out_v_q) else $error("result overwritten");
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (busy || done)) else $error("event lost");

endmodule

`default_nettype wire
